@@ rtl/core/swrm_pkg.sv @@
package swrm_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ENTRY_W     = 7;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [ENTRY_W-1:0]       entry_t;

  localparam word_t INT_MAX   = 32'sh7FFF_FFFF;
  localparam cnt_t  CNT_FULL  = CNT_W'(STACK_DEPTH);
  localparam cnt_t  CNT_EMPTY = '0;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } fsm_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

@@ rtl/core/swrm_if.sv @@
interface swrm_in_if;
  import swrm_pkg::*;

  logic  valid;
  logic  ready;
  req_t  req_type;
  word_t data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink   (input valid, input req_type, input data_value, output ready);
endinterface

interface swrm_out_if;
  import swrm_pkg::*;

  logic    valid;
  logic    ready;
  word_t   popped_value;
  word_t   current_min;
  status_t status;
  entry_t  entry_count;

  modport source (output valid, output popped_value, output current_min, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input current_min, input status,
                  input entry_count, output ready);
endinterface

@@ rtl/core/swrm_ram.sv @@
module swrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/swrm_ctrl.sv @@
module swrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  swrm_in_if.sink            in_ch,
  swrm_out_if.source         out_ch,
  output swrm_pkg::mem_req_t val_req,
  output swrm_pkg::mem_req_t min_req,
  input  swrm_pkg::word_t    val_rdata,
  input  swrm_pkg::word_t    min_rdata
);
  import swrm_pkg::*;

  fsm_t    state_r, state_nxt;
  cnt_t    vcnt_r, vcnt_nxt;
  cnt_t    mcnt_r, mcnt_nxt;
  word_t   top_val_r, top_val_nxt;
  word_t   min_r, min_nxt;
  logic    pop_min_r, pop_min_nxt;
  logic    out_valid_r, out_valid_nxt;
  word_t   popped_r, popped_nxt;
  word_t   omin_r, omin_nxt;
  status_t status_r, status_nxt;
  cnt_t    ocnt_r, ocnt_nxt;

  logic out_free, in_rdy, acc, is_pop, push_ok, pop_ok, push_le, min_push, pop_min;

  assign out_free = !out_valid_r || out_ch.ready;
  assign acc      = in_ch.valid && in_rdy;
  assign is_pop   = (in_ch.req_type == REQ_POP);
  assign push_ok  = (vcnt_r != CNT_FULL);
  assign pop_ok   = (vcnt_r != CNT_EMPTY);
  assign push_le  = (in_ch.data_value <= min_r);
  assign min_push = push_le && (mcnt_r != CNT_FULL);
  assign pop_min  = (top_val_r == min_r) && (mcnt_r != CNT_EMPTY);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc && is_pop && pop_ok) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_rdy        = 1'b0;
    val_req.we    = 1'b0;
    min_req.we    = 1'b0;
    val_req.waddr = ADDR_W'(vcnt_r);
    val_req.wdata = in_ch.data_value;
    val_req.raddr = ADDR_W'(vcnt_r - CNT_W'(2));
    min_req.waddr = ADDR_W'(mcnt_r);
    min_req.wdata = in_ch.data_value;
    min_req.raddr = ADDR_W'(mcnt_r - CNT_W'(2));
    case (state_r)
      S_IDLE: begin
        in_rdy     = out_free;
        val_req.we = acc && !is_pop && push_ok;
        min_req.we = acc && !is_pop && push_ok && min_push;
      end
      S_LOAD:  in_rdy = 1'b0;
      default: in_rdy = 1'b0;
    endcase
  end

  assign in_ch.ready = in_rdy;

  always_comb begin
    vcnt_nxt      = vcnt_r;
    mcnt_nxt      = mcnt_r;
    top_val_nxt   = top_val_r;
    min_nxt       = min_r;
    pop_min_nxt   = pop_min_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    popped_nxt    = popped_r;
    omin_nxt      = omin_r;
    status_nxt    = status_r;
    ocnt_nxt      = ocnt_r;
    if (acc) begin
      popped_nxt    = '0;
      status_nxt    = ST_OK;
      omin_nxt      = min_r;
      ocnt_nxt      = vcnt_r;
      out_valid_nxt = 1'b1;
      if (!is_pop) begin
        if (push_ok) begin
          vcnt_nxt    = vcnt_r + CNT_W'(1);
          ocnt_nxt    = vcnt_r + CNT_W'(1);
          top_val_nxt = in_ch.data_value;
          if (min_push) begin
            mcnt_nxt = mcnt_r + CNT_W'(1);
            min_nxt  = in_ch.data_value;
            omin_nxt = in_ch.data_value;
          end
        end else begin
          status_nxt = ST_PUSH_FULL;
        end
      end else if (pop_ok) begin
        vcnt_nxt      = vcnt_r - CNT_W'(1);
        popped_nxt    = top_val_r;
        pop_min_nxt   = pop_min;
        out_valid_nxt = 1'b0;
        if (pop_min) begin
          mcnt_nxt = mcnt_r - CNT_W'(1);
        end
      end else begin
        status_nxt = ST_POP_EMPTY;
      end
    end else if (state_r == S_LOAD) begin
      top_val_nxt = val_rdata;
      if (pop_min_r) begin
        min_nxt = (mcnt_r == CNT_EMPTY) ? INT_MAX : min_rdata;
      end
      omin_nxt      = pop_min_r ? ((mcnt_r == CNT_EMPTY) ? INT_MAX : min_rdata) : min_r;
      status_nxt    = ST_OK;
      ocnt_nxt      = vcnt_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcnt_r      <= CNT_EMPTY;
      mcnt_r      <= CNT_EMPTY;
      min_r       <= INT_MAX;
      pop_min_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      mcnt_r      <= mcnt_nxt;
      min_r       <= min_nxt;
      pop_min_r   <= pop_min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    popped_r  <= popped_nxt;
    omin_r    <= omin_nxt;
    status_r  <= status_nxt;
    ocnt_r    <= ocnt_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.current_min  = omin_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = ENTRY_W'(ocnt_r);

endmodule

@@ rtl/core/stack_with_running_minimum_unit.sv @@
// Push, rejected push and rejected pop: the result is registered directly from the transfer.
// Successful pop: the value and minimum memories are read at the transfer, S_LOAD refills
// the top-of-stack registers from the read data, and the result is registered in S_LOAD.
// One request in flight: a push every cycle while out is drained; a pop takes no new request until S_LOAD is done.
// Reset (synchronous, active low) empties both stacks and sets the minimum to INT_MAX;
// memory contents are not cleared and no clearing pass is run.
module stack_with_running_minimum_unit (
  input logic        clk,
  input logic        rst_n,
  swrm_in_if.sink    in_ch,
  swrm_out_if.source out_ch
);
  import swrm_pkg::*;

  mem_req_t val_req, min_req;
  word_t    val_rdata, min_rdata;

  swrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .val_req   (val_req),
    .min_req   (min_req),
    .val_rdata (val_rdata),
    .min_rdata (min_rdata)
  );

  swrm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_req.we),
    .waddr (val_req.waddr),
    .wdata (val_req.wdata),
    .raddr (val_req.raddr),
    .rdata (val_rdata)
  );

  swrm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (min_req.we),
    .waddr (min_req.waddr),
    .wdata (min_req.wdata),
    .raddr (min_req.raddr),
    .rdata (min_rdata)
  );

endmodule
